[rtl/baro_pressure_compensation_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pressure compensation block
// Clocked property checks shared by the RTL that carries assertions.
// ----------------------------------------------------------------------------
`ifndef BARO_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_COMPENSATION_ASSERT_SVH

// check outside reset
`define BPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that also covers the reset cycles
`define BPC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// bpc_pkg
// Widths, clamp limits and register indexes of the pressure compensation.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int RAW_W     = 24;
    localparam int TEMP_W    = 19;
    localparam int PRESS_W   = 22;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;
    localparam int NSTG      = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS        = 3'd0,
        CFG_OFFSET      = 3'd1,
        CFG_SENS_TEMP   = 3'd2,
        CFG_OFFSET_TEMP = 3'd3,
        CFG_REF_TEMP    = 3'd4,
        CFG_TEMP_SLOPE  = 3'd5
    } t_cfg_idx;

    localparam logic signed [35:0] OFF_MAX  = 36'sd12884705280;
    localparam logic signed [35:0] OFF_MIN  = -36'sd8589672450;
    localparam logic signed [34:0] SENS_MAX = 35'sd6442352640;
    localparam logic signed [34:0] SENS_MIN = -35'sd4294836225;

    localparam logic signed [41:0]       TRUNC_BIAS = 42'sd8388607;
    localparam logic signed [TEMP_W-1:0] TEMP_BASE  = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_LO    = -19'sd129072;
    localparam logic signed [TEMP_W-1:0] TEMP_HI    = 19'sd133072;

endpackage

[rtl/baro_pressure_compensation.sv]
// ----------------------------------------------------------------------------
// baro_pressure_compensation
// First-order temperature compensation of raw barometric conversions.
//
// Usage:
//   Slave stream s_axis_* takes one word per sample pair: raw pressure D1 and
//   raw temperature D2. Master stream m_axis_* returns one word per pair:
//   temperature in 0.01 degC, pressure in Pa and a pressure-above-zero flag.
//   The six calibration words C1..C6 are written through i_cfg_we /
//   i_cfg_index / i_cfg_wdata while the stream is idle; writes to indexes
//   above five are ignored.
//   An accepted input word passes through the six pipeline stages before it leaves.
//   Throughput is one word per cycle while m_axis_tready stays high; the
//   long product D1*SENS is split into two 24x17 partial products.
//   Reset clears the pipeline and sets all calibration words to zero.
//   When the receiver stalls, each stage holds its word; empty stages keep
//   filling, so s_axis_tready drops only when all six stages are occupied.
// ----------------------------------------------------------------------------
`include "baro_pressure_compensation_assert.svh"

module baro_pressure_compensation (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bpc_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [23:0] raw_pressure, [47:24] raw_temperature
    input  logic [bpc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [18:0] temperature_centi, [40:19] pressure_pa, [41] pressure_positive,
    // [47:42] zero
    output logic [bpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import bpc_pkg::*;

    logic [CFG_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;
    logic            w_in_acc;
    logic            w_out_acc;

    logic [RAW_W-1:0]        r_s1_d1;
    logic signed [24:0]      r_s1_dt;
    logic [RAW_W-1:0]        r_s2_d1;
    logic signed [41:0]      r_s2_pt, r_s2_po, r_s2_ps;
    logic [RAW_W-1:0]        r_s3_d1;
    logic signed [TEMP_W-1:0] r_s3_temp;
    logic signed [34:0]      r_s3_off;
    logic signed [33:0]      r_s3_sens;
    logic signed [TEMP_W-1:0] r_s4_temp;
    logic signed [34:0]      r_s4_off;
    logic [40:0]             r_s4_ppl;
    logic signed [40:0]      r_s4_pph;
    logic signed [TEMP_W-1:0] r_s5_temp;
    logic signed [34:0]      r_s5_off;
    logic signed [36:0]      r_s5_q;
    logic signed [TEMP_W-1:0] r_temp;
    logic signed [PRESS_W-1:0] r_press;
    logic                    r_pos;

    logic signed [24:0]      w_dt;
    logic signed [41:0]      w_pt_bias;
    logic signed [34:0]      w_off_sh;
    logic signed [35:0]      w_off_raw;
    logic signed [35:0]      w_off_clamp;
    logic signed [33:0]      w_sens_sh;
    logic signed [34:0]      w_sens_raw;
    logic signed [34:0]      w_sens_clamp;
    logic signed [57:0]      w_prod;
    logic signed [37:0]      w_diff;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SENS:        r_c1 <= i_cfg_wdata;
                CFG_OFFSET:      r_c2 <= i_cfg_wdata;
                CFG_SENS_TEMP:   r_c3 <= i_cfg_wdata;
                CFG_OFFSET_TEMP: r_c4 <= i_cfg_wdata;
                CFG_REF_TEMP:    r_c5 <= i_cfg_wdata;
                CFG_TEMP_SLOPE:  r_c6 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-stage advance: a stage loads when empty or when its word moves on
    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign s_axis_tready = w_adv[0];
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: dT
    assign w_dt = $signed({1'b0, s_axis_tdata[47:24]}) - $signed({1'b0, r_c5, 8'h00});

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_s1_d1 <= s_axis_tdata[23:0];
            r_s1_dt <= w_dt;
        end
    end

    // stage 2: dT products
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s2_d1 <= r_s1_d1;
            r_s2_pt <= r_s1_dt * $signed({1'b0, r_c6});
            r_s2_po <= r_s1_dt * $signed({1'b0, r_c4});
            r_s2_ps <= r_s1_dt * $signed({1'b0, r_c3});
        end
    end

    // stage 3: temperature, OFF and SENS with clamping
    assign w_pt_bias  = r_s2_pt + (r_s2_pt[41] ? TRUNC_BIAS : 42'sd0);
    assign w_off_sh   = r_s2_po[41:7];
    assign w_off_raw  = $signed({4'b0, r_c2, 16'h0000}) + $signed({w_off_sh[34], w_off_sh});
    assign w_sens_sh  = r_s2_ps[41:8];
    assign w_sens_raw = $signed({4'b0, r_c1, 15'h0000}) + $signed({w_sens_sh[33], w_sens_sh});

    always_comb begin
        priority if (w_off_raw > OFF_MAX) begin
            w_off_clamp = OFF_MAX;
        end else if (w_off_raw < OFF_MIN) begin
            w_off_clamp = OFF_MIN;
        end else begin
            w_off_clamp = w_off_raw;
        end
    end

    always_comb begin
        priority if (w_sens_raw > SENS_MAX) begin
            w_sens_clamp = SENS_MAX;
        end else if (w_sens_raw < SENS_MIN) begin
            w_sens_clamp = SENS_MIN;
        end else begin
            w_sens_clamp = w_sens_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_s3_d1   <= r_s2_d1;
            r_s3_temp <= $signed(w_pt_bias[41:23]) + TEMP_BASE;
            r_s3_off  <= w_off_clamp[34:0];
            r_s3_sens <= w_sens_clamp[33:0];
        end
    end

    // stage 4: partial products of D1*SENS
    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_s4_temp <= r_s3_temp;
            r_s4_off  <= r_s3_off;
            r_s4_ppl  <= r_s3_d1 * r_s3_sens[16:0];
            r_s4_pph  <= $signed({17'h00000, r_s3_d1}) *
                         $signed({{24{r_s3_sens[33]}}, r_s3_sens[33:17]});
        end
    end

    // stage 5: combine partial products, drop 21 bits
    assign w_prod = $signed({r_s4_pph, 17'h00000}) + $signed({17'h00000, r_s4_ppl});

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_s5_temp <= r_s4_temp;
            r_s5_off  <= r_s4_off;
            r_s5_q    <= w_prod[57:21];
        end
    end

    // stage 6: subtract OFF, drop 15 bits
    assign w_diff = $signed({r_s5_q[36], r_s5_q}) - $signed({{3{r_s5_off[34]}}, r_s5_off});

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_temp  <= r_s5_temp;
            r_press <= w_diff[36:15];
            r_pos   <= !w_diff[37] && (w_diff[37:15] != 23'd0);
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {6'b000000, r_pos, r_press, r_temp};

    `BPC_ASSERT_RST(a_rst_empty, !i_rst_n |=> (r_vld == '0), "pipeline not empty after reset")
    `BPC_ASSERT(a_ready_free, (r_vld != '1) |-> s_axis_tready, "ready low with a free stage")
    `BPC_ASSERT(a_occupancy, $past(i_rst_n) |-> ($countones(r_vld) == $past($countones(r_vld)) + $past(w_in_acc) - $past(w_out_acc)), "word lost or repeated in pipeline")
    `BPC_ASSERT(a_temp_range, m_axis_tvalid |-> (r_temp >= TEMP_LO && r_temp <= TEMP_HI), "temperature out of range")

endmodule
